// ===== src/index_range_first_fit_allocator_assert.svh =====
// Assertion macros for the index range allocator.
`ifndef INDEX_RANGE_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define INDEX_RANGE_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Condition holds at every edge out of reset.
`define IRFFA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IRFFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/irffa_pkg.sv =====
// Shared types, constants and cell control decode for the index range allocator.
`default_nettype none
package irffa_pkg;

   localparam int FREE_RANGES   = 64;
   localparam int PENDING_FREES = 32;
   localparam int FIDX_W = $clog2(FREE_RANGES);
   localparam int FCNT_W = $clog2(FREE_RANGES + 1);
   localparam int PIDX_W = $clog2(PENDING_FREES);
   localparam int PCNT_W = $clog2(PENDING_FREES + 1);

   localparam int START_W  = 24;
   localparam int COUNT_W  = 25;
   localparam int DELAY_W  = 4;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   localparam logic [COUNT_W-1:0] SPACE_LIMIT = COUNT_W'(1) << START_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_QFULL   = 3'd2,
      ST_ZERO    = 3'd3,
      ST_DROP    = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_CAPACITY = 1'b0,
      CSR_DELAY    = 1'b1
   } csr_type;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] len;
      logic [DELAY_W-1:0] delay;
   } entry_type;

   typedef enum logic [2:0] {
      C_HOLD = 3'd0,
      C_NEXT = 3'd1,
      C_PREV = 3'd2,
      C_LOAD = 3'd3,
      C_DEC  = 3'd4
   } cell_ctl_type;

   typedef enum logic [2:0] {
      T_HOLD = 3'd0,
      T_ROT  = 3'd1,
      T_SHL  = 3'd2,
      T_SHR  = 3'd3,
      T_WR   = 3'd4,
      T_DEC  = 3'd5
   } tbl_op_type;

   typedef struct packed {
      cell_ctl_type ctl;
      entry_type    load;
   } cell_in_type;

   function automatic cell_ctl_type cell_ctl(tbl_op_type op, logic above, logic at,
                                             logic last);
      cell_ctl_type ctl;
      ctl = C_HOLD;
      case (op)
         T_ROT: ctl = C_NEXT;
         T_SHL: ctl = ((above || at) && !last) ? C_NEXT : C_HOLD;
         T_SHR: ctl = above ? C_PREV : (at ? C_LOAD : C_HOLD);
         T_WR:  ctl = at ? C_LOAD : C_HOLD;
         T_DEC: ctl = C_DEC;
         default: ctl = C_HOLD;
      endcase
      return ctl;
   endfunction

endpackage
`default_nettype wire

// ===== src/irffa_cell.sv =====
// One table cell: holds a range entry and takes it from a neighbor, a load or a countdown.
`default_nettype none
module irffa_cell (
   input  logic                   clock,
   input  irffa_pkg::cell_in_type cmd,
   input  irffa_pkg::entry_type   next_d,
   input  irffa_pkg::entry_type   prev_d,
   output irffa_pkg::entry_type   entry_q
);

   irffa_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.ctl)
         irffa_pkg::C_NEXT: entry_in = next_d;
         irffa_pkg::C_PREV: entry_in = prev_d;
         irffa_pkg::C_LOAD: entry_in = cmd.load;
         irffa_pkg::C_DEC:  entry_in.delay = entry_ff.delay - irffa_pkg::DELAY_W'(1);
         default:           entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule
`default_nettype wire

// ===== src/index_range_first_fit_allocator.sv =====
// Top level: first-fit index range allocator with deferred, coalescing frees.
//
// The free-range table and the pending-free queue are rows of cells that rotate
// their entries past a head cell, one entry per cycle; every search is one full
// rotation. An allocate scans the free table and then fixes it up, and a queued
// free writes one queue entry. A frame tick decrements every delay; then each
// expiring range is found by a pending-queue scan, taken out of the queue and
// merged by either one or two free-table rotations, or, when it meets the tail,
// by one rotation per table range that the tail swallows plus one that finds none
// unless the table runs empty. One item is in work at a time; the result beat
// waits in an output register while the next item is taken.
`default_nettype none
`include "index_range_first_fit_allocator_assert.svh"
module index_range_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // range_start[23:0], range_count[48:24], zero fill
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // alloc_offset[23:0], tail_offset[48:24], zero fill
   output logic [2:0]  rsp_tuser,   // status[2:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [24:0] csr_wdata
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_ASCAN   = 13'b0000000000010,
      S_AFIX    = 13'b0000000000100,
      S_FREE    = 13'b0000000001000,
      S_TDEC    = 13'b0000000010000,
      S_PSCAN   = 13'b0000000100000,
      S_PREM    = 13'b0000001000000,
      S_GBSTART = 13'b0000010000000,
      S_TSCAN   = 13'b0000100000000,
      S_TREM    = 13'b0001000000000,
      S_FSCAN   = 13'b0010000000000,
      S_MERGE   = 13'b0100000000000,
      S_DONE    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [irffa_pkg::FIDX_W-1:0]  fk_ff, fk_in, pos_ff, pos_in;
   logic [irffa_pkg::PIDX_W-1:0]  pk_ff, pk_in, ppos_ff, ppos_in;
   logic                          found_ff, found_in, pfound_ff, pfound_in;
   logic                          merged_ff, merged_in;
   logic [irffa_pkg::FCNT_W-1:0]  used_ff, used_in;
   logic [irffa_pkg::PCNT_W-1:0]  pused_ff, pused_in;
   logic [irffa_pkg::COUNT_W-1:0] tail_ff, tail_in, cap_ff, cap_in, c_ff, c_in;
   logic [irffa_pkg::DELAY_W-1:0] dly_ff, dly_in;
   logic [irffa_pkg::START_W-1:0] s_ff, s_in, offset_ff, offset_in;
   irffa_pkg::status_type         status_ff, status_in, rsp_status_ff, rsp_status_in;
   irffa_pkg::entry_type          ent_ff, ent_in, last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [irffa_pkg::START_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [irffa_pkg::COUNT_W-1:0] rsp_tail_ff, rsp_tail_in;

   irffa_pkg::tbl_op_type         fop, pop;
   logic [irffa_pkg::FCNT_W-1:0]  fidx;
   logic [irffa_pkg::PCNT_W-1:0]  pidx;
   irffa_pkg::entry_type          fdata, pdata;
   irffa_pkg::entry_type          fq [irffa_pkg::FREE_RANGES];
   irffa_pkg::entry_type          pq [irffa_pkg::PENDING_FREES];

   irffa_pkg::entry_type          fhead, phead;
   logic                          f_live, p_live, f_last, p_last;
   logic                          fit_hit, tail_hit, pos_hit, exp_hit;
   logic [irffa_pkg::COUNT_W:0]   fhead_end, give_end, last_end, alloc_end;
   logic [irffa_pkg::FCNT_W-1:0]  posv;
   logic [irffa_pkg::COUNT_W-1:0] cap_eff;
   irffa_pkg::cmd_type            req_cmd;
   logic [irffa_pkg::START_W-1:0] req_start;
   logic [irffa_pkg::COUNT_W-1:0] req_count;

   for (genvar i = 0; i < irffa_pkg::FREE_RANGES; i++) begin : g_free
      irffa_pkg::cell_in_type cin;
      assign cin = {irffa_pkg::cell_ctl(fop, irffa_pkg::FCNT_W'(i) > fidx,
                                        irffa_pkg::FCNT_W'(i) == fidx,
                                        i == irffa_pkg::FREE_RANGES - 1),
                    fdata};
      irffa_cell u_cell (
         .clock   (clock),
         .cmd     (cin),
         .next_d  (fq[(i + 1) % irffa_pkg::FREE_RANGES]),
         .prev_d  (fq[(i + irffa_pkg::FREE_RANGES - 1) % irffa_pkg::FREE_RANGES]),
         .entry_q (fq[i])
      );
   end

   for (genvar i = 0; i < irffa_pkg::PENDING_FREES; i++) begin : g_pend
      irffa_pkg::cell_in_type cin;
      assign cin = {irffa_pkg::cell_ctl(pop, irffa_pkg::PCNT_W'(i) > pidx,
                                        irffa_pkg::PCNT_W'(i) == pidx,
                                        i == irffa_pkg::PENDING_FREES - 1),
                    pdata};
      irffa_cell u_cell (
         .clock   (clock),
         .cmd     (cin),
         .next_d  (pq[(i + 1) % irffa_pkg::PENDING_FREES]),
         .prev_d  (pq[(i + irffa_pkg::PENDING_FREES - 1) % irffa_pkg::PENDING_FREES]),
         .entry_q (pq[i])
      );
   end

   assign req_cmd   = irffa_pkg::cmd_type'(req_tuser);
   assign req_start = req_tdata[23:0];
   assign req_count = req_tdata[48:24];

   assign fhead     = fq[0];
   assign phead     = pq[0];
   assign f_live    = irffa_pkg::FCNT_W'(fk_ff) < used_ff;
   assign p_live    = irffa_pkg::PCNT_W'(pk_ff) < pused_ff;
   assign f_last    = fk_ff == irffa_pkg::FIDX_W'(irffa_pkg::FREE_RANGES - 1);
   assign p_last    = pk_ff == irffa_pkg::PIDX_W'(irffa_pkg::PENDING_FREES - 1);
   assign fhead_end = {2'b00, fhead.start} + {1'b0, fhead.len};
   assign give_end  = {2'b00, s_ff} + {1'b0, c_ff};
   assign last_end  = {2'b00, last_ff.start} + {1'b0, last_ff.len};
   assign alloc_end = {1'b0, tail_ff} + {1'b0, c_ff};
   assign fit_hit   = f_live && !found_ff && (fhead.len >= c_ff);
   assign tail_hit  = f_live && !found_ff && (fhead_end == {1'b0, tail_ff});
   assign pos_hit   = f_live && !found_ff && (fhead.start >= s_ff);
   assign exp_hit   = p_live && !pfound_ff && (phead.delay == '0);
   assign posv      = found_ff ? irffa_pkg::FCNT_W'(pos_ff) : used_ff;
   assign cap_eff   = (cap_ff > irffa_pkg::SPACE_LIMIT) ? irffa_pkg::SPACE_LIMIT : cap_ff;

   always_comb begin
      state_in      = state_ff;
      fk_in         = fk_ff;
      pk_in         = pk_ff;
      pos_in        = pos_ff;
      ppos_in       = ppos_ff;
      found_in      = found_ff;
      pfound_in     = pfound_ff;
      merged_in     = merged_ff;
      used_in       = used_ff;
      pused_in      = pused_ff;
      tail_in       = tail_ff;
      cap_in        = cap_ff;
      dly_in        = dly_ff;
      s_in          = s_ff;
      c_in          = c_ff;
      offset_in     = offset_ff;
      status_in     = status_ff;
      ent_in        = ent_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_tail_in   = rsp_tail_ff;
      fop           = irffa_pkg::T_HOLD;
      fidx          = '0;
      fdata         = ent_ff;
      pop           = irffa_pkg::T_HOLD;
      pidx          = '0;
      pdata         = ent_ff;

      if (csr_we) begin
         unique case (irffa_pkg::csr_type'(csr_addr))
            irffa_pkg::CSR_CAPACITY: cap_in = csr_wdata;
            irffa_pkg::CSR_DELAY:    dly_in = csr_wdata[irffa_pkg::DELAY_W-1:0];
            default:                 cap_in = cap_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               s_in      = req_start;
               c_in      = req_count;
               status_in = irffa_pkg::ST_OK;
               offset_in = '0;
               fk_in     = '0;
               found_in  = 1'b0;
               unique case (req_cmd)
                  irffa_pkg::CMD_ALLOC: begin
                     if (req_count == '0) begin
                        status_in = irffa_pkg::ST_ZERO;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ASCAN;
                     end
                  end
                  irffa_pkg::CMD_FREE: state_in = S_FREE;
                  irffa_pkg::CMD_TICK: state_in = S_TDEC;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_ASCAN: begin
            fop   = irffa_pkg::T_ROT;
            fk_in = fk_ff + irffa_pkg::FIDX_W'(1);
            if (fit_hit) begin
               found_in = 1'b1;
               pos_in   = fk_ff;
               ent_in   = fhead;
            end
            if (f_last) state_in = S_AFIX;
         end
         S_AFIX: begin
            if (found_ff) begin
               offset_in = ent_ff.start;
               fidx      = irffa_pkg::FCNT_W'(pos_ff);
               if (ent_ff.len > c_ff) begin
                  fop         = irffa_pkg::T_WR;
                  fdata.start = ent_ff.start + c_ff[irffa_pkg::START_W-1:0];
                  fdata.len   = ent_ff.len - c_ff;
               end else begin
                  fop     = irffa_pkg::T_SHL;
                  used_in = used_ff - irffa_pkg::FCNT_W'(1);
               end
            end else if (alloc_end > {1'b0, cap_eff}) begin
               status_in = irffa_pkg::ST_NOSPACE;
            end else begin
               offset_in = tail_ff[irffa_pkg::START_W-1:0];
               tail_in   = alloc_end[irffa_pkg::COUNT_W-1:0];
            end
            state_in = S_DONE;
         end
         S_FREE: begin
            if (c_ff == '0) begin
               status_in = irffa_pkg::ST_ZERO;
            end else if (pused_ff == irffa_pkg::PCNT_W'(irffa_pkg::PENDING_FREES)) begin
               status_in = irffa_pkg::ST_QFULL;
            end else begin
               pop         = irffa_pkg::T_WR;
               pidx        = pused_ff;
               pdata.start = s_ff;
               pdata.len   = (give_end > {1'b0, irffa_pkg::SPACE_LIMIT}) ?
                             irffa_pkg::SPACE_LIMIT - {1'b0, s_ff} : c_ff;
               pdata.delay = (dly_ff == '0) ? irffa_pkg::DELAY_W'(1) : dly_ff;
               pused_in    = pused_ff + irffa_pkg::PCNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_TDEC: begin
            pop       = irffa_pkg::T_DEC;
            pk_in     = '0;
            pfound_in = 1'b0;
            state_in  = S_PSCAN;
         end
         S_PSCAN: begin
            pop   = irffa_pkg::T_ROT;
            pk_in = pk_ff + irffa_pkg::PIDX_W'(1);
            if (exp_hit) begin
               pfound_in = 1'b1;
               ppos_in   = pk_ff;
               s_in      = phead.start;
               c_in      = phead.len;
            end
            if (p_last) state_in = S_PREM;
         end
         S_PREM: begin
            if (pfound_ff) begin
               pop      = irffa_pkg::T_SHL;
               pidx     = irffa_pkg::PCNT_W'(ppos_ff);
               pused_in = pused_ff - irffa_pkg::PCNT_W'(1);
               state_in = S_GBSTART;
            end else begin
               state_in = S_DONE;
            end
         end
         S_GBSTART: begin
            fk_in    = '0;
            found_in = 1'b0;
            if (give_end == {1'b0, tail_ff}) begin
               tail_in = {1'b0, s_ff};
               if (used_ff != '0) begin
                  state_in = S_TSCAN;
               end else begin
                  pk_in     = '0;
                  pfound_in = 1'b0;
                  state_in  = S_PSCAN;
               end
            end else begin
               merged_in = 1'b0;
               state_in  = S_FSCAN;
            end
         end
         S_TSCAN: begin
            fop   = irffa_pkg::T_ROT;
            fk_in = fk_ff + irffa_pkg::FIDX_W'(1);
            if (tail_hit) begin
               found_in = 1'b1;
               pos_in   = fk_ff;
               ent_in   = fhead;
            end
            if (f_last) state_in = S_TREM;
         end
         S_TREM: begin
            fk_in     = '0;
            found_in  = 1'b0;
            pk_in     = '0;
            pfound_in = 1'b0;
            state_in  = S_PSCAN;
            if (found_ff) begin
               tail_in = {1'b0, ent_ff.start};
               fop     = irffa_pkg::T_SHL;
               fidx    = irffa_pkg::FCNT_W'(pos_ff);
               used_in = used_ff - irffa_pkg::FCNT_W'(1);
               if (used_ff != irffa_pkg::FCNT_W'(1)) state_in = S_TSCAN;
            end
         end
         S_FSCAN: begin
            fop   = irffa_pkg::T_ROT;
            fk_in = fk_ff + irffa_pkg::FIDX_W'(1);
            if (pos_hit) begin
               found_in = 1'b1;
               pos_in   = fk_ff;
               ent_in   = fhead;
            end else if (f_live && !found_ff) begin
               last_in = fhead;
            end
            if (f_last) state_in = S_MERGE;
         end
         S_MERGE: begin
            fk_in    = '0;
            found_in = 1'b0;
            if (!merged_ff && posv != '0 && last_end == {2'b00, s_ff}) begin
               c_in      = irffa_pkg::COUNT_W'({1'b0, last_ff.len} + {1'b0, c_ff});
               s_in      = last_ff.start;
               fop       = irffa_pkg::T_SHL;
               fidx      = posv - irffa_pkg::FCNT_W'(1);
               used_in   = used_ff - irffa_pkg::FCNT_W'(1);
               merged_in = 1'b1;
               state_in  = S_FSCAN;
            end else begin
               if (found_ff && give_end == {2'b00, ent_ff.start}) begin
                  fop         = irffa_pkg::T_WR;
                  fidx        = irffa_pkg::FCNT_W'(pos_ff);
                  fdata.start = s_ff;
                  fdata.len   = irffa_pkg::COUNT_W'({1'b0, ent_ff.len} + {1'b0, c_ff});
               end else if (used_ff == irffa_pkg::FCNT_W'(irffa_pkg::FREE_RANGES)) begin
                  status_in = irffa_pkg::ST_DROP;
               end else begin
                  fop         = irffa_pkg::T_SHR;
                  fidx        = posv;
                  fdata.start = s_ff;
                  fdata.len   = c_ff;
                  used_in     = used_ff + irffa_pkg::FCNT_W'(1);
               end
               pk_in     = '0;
               pfound_in = 1'b0;
               state_in  = S_PSCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = offset_ff;
               rsp_tail_in   = tail_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         pused_ff     <= '0;
         tail_ff      <= '0;
         cap_ff       <= irffa_pkg::SPACE_LIMIT;
         dly_ff       <= irffa_pkg::DELAY_W'(2);
         rsp_valid_ff <= 1'b0;
         fk_ff        <= '0;
         pk_ff        <= '0;
         found_ff     <= 1'b0;
         pfound_ff    <= 1'b0;
         merged_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pused_ff     <= pused_in;
         tail_ff      <= tail_in;
         cap_ff       <= cap_in;
         dly_ff       <= dly_in;
         rsp_valid_ff <= rsp_valid_in;
         fk_ff        <= fk_in;
         pk_ff        <= pk_in;
         found_ff     <= found_in;
         pfound_ff    <= pfound_in;
         merged_ff    <= merged_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      ppos_ff       <= ppos_in;
      s_ff          <= s_in;
      c_ff          <= c_in;
      offset_ff     <= offset_in;
      status_ff     <= status_in;
      ent_ff        <= ent_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_tail_ff   <= rsp_tail_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_tail_ff, rsp_offset_ff};

   `IRFFA_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= irffa_pkg::FCNT_W'(irffa_pkg::FREE_RANGES), "free table count past depth")
   `IRFFA_ASSERT_ALWAYS(a_pused_bound, clock, reset, pused_ff <= irffa_pkg::PCNT_W'(irffa_pkg::PENDING_FREES), "pending count past depth")
   `IRFFA_ASSERT_ALWAYS(a_tail_bound, clock, reset, tail_ff <= irffa_pkg::SPACE_LIMIT, "tail past index space")
   `IRFFA_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready && !reset, state_ff != S_IDLE, "accepted beat left block idle")

endmodule
`default_nettype wire
